FILE: hdl/cansv_pkg.sv
// Shared types and constants for the CAN speed frame validator.
// No dependencies; imported by every module of the block.
package cansv_pkg;

   localparam logic [10:0] FRAME_ID      = 11'h29A;
   localparam logic [3:0]  DLC_EXPECTED  = 4'd8;
   localparam logic [15:0] SPEED_INVALID = 16'hFFFF;
   localparam logic [15:0] SPEED_LIMIT   = 16'd50000;
   localparam logic [1:0]  BUS_SPEED     = 2'd0;

   localparam logic [1:0] CSR_PROFILE_ENABLE  = 2'd0;
   localparam logic [1:0] CSR_EXT_SPEED_EN    = 2'd1;
   localparam logic [1:0] CSR_WIRED_SPEED_IN  = 2'd2;

   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_RESET = 1'b1;

   typedef enum logic [2:0] {
      ST_FILTERED = 3'd0,
      ST_BAD_SUM  = 3'd1,
      ST_REPEAT   = 3'd2,
      ST_INVALID  = 3'd3,
      ST_UPDATED  = 3'd4,
      ST_RESET    = 3'd5
   } status_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  bus_index;
      logic        is_extended;
      logic        is_remote;
      logic [10:0] frame_id;
      logic [3:0]  data_length;
      logic [63:0] payload;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        speed_valid;
      logic [15:0] speed_value;
   } rsp_type;

   // classified transaction passed from front to back
   typedef struct packed {
      logic        is_reset;
      logic        accepted;
      logic        sum_ok;
      logic [3:0]  counter;
      logic        raw_invalid;
      logic [15:0] speed;
   } cls_type;

endpackage

FILE: hdl/cansv_front.sv
// Front stage: accepts request transactions, filters and checks each frame.
// Depends on cansv_pkg; feeds the classification queue.
module cansv_front
   import cansv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    enabled,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    q_full,
   output logic    q_push,
   output cls_type q_data
);

   logic    valid_ff, valid_in;
   cls_type cls_ff, cls_in;
   logic    take;
   logic [7:0]  sum;
   logic [15:0] raw;

   always_comb begin
      sum = 8'd0;
      for (int i = 0; i < 7; i++) begin
         sum = sum + req_data.payload[i*8 +: 8];
      end
      raw = {req_data.payload[39:32], req_data.payload[47:40]};

      cls_in.is_reset    = (req_data.kind == KIND_RESET);
      cls_in.accepted    = enabled && (req_data.bus_index == BUS_SPEED)
                           && !req_data.is_extended && !req_data.is_remote
                           && (req_data.frame_id == FRAME_ID)
                           && (req_data.data_length == DLC_EXPECTED);
      cls_in.sum_ok      = (req_data.payload[63:56] == ~sum);
      cls_in.counter     = req_data.payload[51:48];
      cls_in.raw_invalid = (raw == SPEED_INVALID);
      cls_in.speed       = (raw > SPEED_LIMIT) ? SPEED_LIMIT : raw;
   end

   assign q_push    = valid_ff && !q_full;
   assign req_stall = valid_ff && q_full;
   assign take      = req_valid && !req_stall;
   assign q_data    = cls_ff;

   always_comb begin
      valid_in = take ? 1'b1 : (q_push ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         cls_ff <= cls_in;
      end
   end

endmodule

FILE: hdl/cansv_fifo.sv
// Short queue between front and back stages, fall-through read.
// Depends on cansv_pkg for the classified transaction type.
module cansv_fifo
   import cansv_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cls_type push_data,
   output logic    full,
   input  logic    pop,
   output cls_type pop_data,
   output logic    empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

   cls_type         mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full     = (count_ff == CntW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/cansv_back.sv
// Back stage: applies classified transactions to decoder state, drives result.
// Depends on cansv_pkg; pops the classification queue.
module cansv_back
   import cansv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  cls_type q_data,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic        seen_ff, seen_in;
   logic [3:0]  last_ctr_ff, last_ctr_in;
   logic [15:0] speed_ff, speed_in;
   logic        spd_valid_ff, spd_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  status_ff, status_in;

   assign q_pop = !q_empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      seen_in      = seen_ff;
      last_ctr_in  = last_ctr_ff;
      speed_in     = speed_ff;
      spd_valid_in = spd_valid_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (q_pop) begin
         rsp_valid_in = 1'b1;
         if (q_data.is_reset) begin
            seen_in      = 1'b0;
            last_ctr_in  = 4'd0;
            speed_in     = 16'd0;
            spd_valid_in = 1'b0;
            status_in    = ST_RESET;
         end else if (!q_data.accepted) begin
            status_in = ST_FILTERED;
         end else if (!q_data.sum_ok) begin
            status_in = ST_BAD_SUM;
         end else if (seen_ff && (q_data.counter == last_ctr_ff)) begin
            status_in = ST_REPEAT;
         end else begin
            seen_in     = 1'b1;
            last_ctr_in = q_data.counter;
            if (q_data.raw_invalid) begin
               speed_in     = 16'd0;
               spd_valid_in = 1'b0;
               status_in    = ST_INVALID;
            end else begin
               speed_in     = q_data.speed;
               spd_valid_in = 1'b1;
               status_in    = ST_UPDATED;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         last_ctr_ff  <= 4'd0;
         speed_ff     <= 16'd0;
         spd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= ST_FILTERED;
      end else begin
         seen_ff      <= seen_in;
         last_ctr_ff  <= last_ctr_in;
         speed_ff     <= speed_in;
         spd_valid_ff <= spd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data.status      = status_ff;
   assign rsp_data.speed_valid = spd_valid_ff;
   assign rsp_data.speed_value = speed_ff;

endmodule

FILE: hdl/can_speed_frame_validator.sv
// Top level of the CAN speed frame validator: config registers and stages.
// Depends on cansv_pkg, cansv_front, cansv_fifo and cansv_back.
//
// Usage:
//   req_* carries one transaction per CAN frame or decoder reset event; it is
//   taken at a clock edge with req_valid high and req_stall low.
//   rsp_* returns exactly one result per request, in order, taken at an edge
//   with rsp_valid high and rsp_stall low.
//   csr_* writes the three enable bits; write only while the block is idle.
// Throughput: one transaction per cycle sustained while rsp_stall stays low.
// Path: a request passes the front register, which loads at the accepting
//   edge, then the queue and then the result register.
// Stall: a stalled result holds; the back stage stops, the queue of
//   QUEUE_DEPTH entries fills, then req_stall rises.
// Reset: clears enables, decoder state and all valid flags; no result pending.
module can_speed_frame_validator
   import cansv_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic       csr_data
);

   logic    prof_en_ff, ext_en_ff, wired_ff;
   logic    enabled;
   logic    q_push, q_pop, q_full, q_empty;
   cls_type q_wr_data, q_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         prof_en_ff <= 1'b0;
         ext_en_ff  <= 1'b0;
         wired_ff   <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PROFILE_ENABLE: begin
               prof_en_ff <= csr_data;
            end
            CSR_EXT_SPEED_EN: begin
               ext_en_ff <= csr_data;
            end
            CSR_WIRED_SPEED_IN: begin
               wired_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign enabled = prof_en_ff && !ext_en_ff && !wired_ff;

   cansv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enabled   (enabled),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_wr_data)
   );

   cansv_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .empty     (q_empty)
   );

   cansv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_rd_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.speed_valid |-> rsp_data.speed_value == 16'd0)
      else $error("speed value nonzero while invalid");

   a_reset_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_RESET |-> !rsp_data.speed_valid)
      else $error("reset transaction left speed valid");

   a_update_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_UPDATED
      |-> rsp_data.speed_valid && rsp_data.speed_value <= SPEED_LIMIT)
      else $error("updated speed out of range or invalid");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");
`endif

endmodule

FILE: sim/can_speed_frame_validator_test.sv
// Self-checking testbench for can_speed_frame_validator: directed and random
// CAN speed frames against a predictor, with random request gaps and result stalls.
// Depends on cansv_pkg and the can_speed_frame_validator RTL.
module can_speed_frame_validator_test
   import cansv_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESULT_LATENCY  = 3;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int RSP_HOLD_CYCLES = 80;
   localparam int RANDOM_CHUNKS   = 12;
   localparam int CHUNK_ITEMS     = 50;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic    csr_data = 1'b0;

   // predictor copy of the enables and decoder state
   logic        cfg_profile = 1'b0;
   logic        cfg_ext_speed = 1'b0;
   logic        cfg_wired = 1'b0;
   logic        seen_counter = 1'b0;
   logic [3:0]  prev_counter = '0;
   logic [15:0] speed_hold = '0;
   logic        speed_ok = 1'b0;

   rsp_type speed_expect_q[$];
   int      fail_count = 0;
   int      cycle_count = 0;
   bit      gaps_on = 1'b1;
   bit      rsp_stall_on = 1'b1;
   int      hold_requests = 0;
   int      hold_served = 0;
   int      hold_left = 0;
   int      stall_run = 0;
   bit      stall_level = 1'b0;

   can_speed_frame_validator uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [7:0] payload_sum(logic [63:0] payload);
      logic [7:0] sum;
      int i;
      sum = '0;
      for (i = 0; i < 7; i++)
         sum += payload[i*8 +: 8];
      return sum;
   endfunction

   // updates the decoder state and returns the expected result
   function automatic rsp_type predict_speed(req_type t);
      rsp_type    r;
      status_type st;
      logic       enabled;
      logic [3:0] ctr;
      logic [15:0] raw;
      enabled = cfg_profile && !cfg_ext_speed && !cfg_wired;
      ctr = t.payload[51:48];
      raw = {t.payload[39:32], t.payload[47:40]};
      if (t.kind == KIND_RESET) begin
         seen_counter = 1'b0;
         prev_counter = '0;
         speed_hold = '0;
         speed_ok = 1'b0;
         st = ST_RESET;
      end else if (!enabled || t.bus_index != BUS_SPEED || t.is_extended || t.is_remote
                   || t.frame_id != FRAME_ID || t.data_length != DLC_EXPECTED) begin
         st = ST_FILTERED;
      end else if (t.payload[63:56] != ~payload_sum(t.payload)) begin
         st = ST_BAD_SUM;
      end else if (seen_counter && ctr == prev_counter) begin
         st = ST_REPEAT;
      end else begin
         seen_counter = 1'b1;
         prev_counter = ctr;
         if (raw == SPEED_INVALID) begin
            speed_ok = 1'b0;
            speed_hold = '0;
            st = ST_INVALID;
         end else begin
            speed_hold = (raw > SPEED_LIMIT) ? SPEED_LIMIT : raw;
            speed_ok = 1'b1;
            st = ST_UPDATED;
         end
      end
      r.status = st;
      r.speed_valid = speed_ok;
      r.speed_value = speed_ok ? speed_hold : '0;
      return r;
   endfunction

   function automatic req_type speed_frame(logic [15:0] raw, logic [3:0] ctr);
      req_type t;
      t.kind = KIND_FRAME;
      t.bus_index = BUS_SPEED;
      t.is_extended = 1'b0;
      t.is_remote = 1'b0;
      t.frame_id = FRAME_ID;
      t.data_length = DLC_EXPECTED;
      t.payload[31:0] = $urandom();
      t.payload[39:32] = raw[15:8];
      t.payload[47:40] = raw[7:0];
      t.payload[55:52] = 4'($urandom_range(0, 15));
      t.payload[51:48] = ctr;
      t.payload[63:56] = ~payload_sum(t.payload);
      return t;
   endfunction

   function automatic req_type random_fields(logic kind);
      req_type t;
      t.kind = kind;
      t.bus_index = 2'($urandom_range(0, 3));
      t.is_extended = 1'($urandom_range(0, 1));
      t.is_remote = 1'($urandom_range(0, 1));
      t.frame_id = 11'($urandom_range(0, 2047));
      t.data_length = 4'($urandom_range(0, 15));
      t.payload = {$urandom(), $urandom()};
      return t;
   endfunction

   function automatic req_type random_item();
      req_type     t;
      logic [15:0] raw;
      logic [3:0]  ctr;
      int          pick;
      case ($urandom_range(0, 9))
         0: raw = SPEED_INVALID;
         1: raw = 16'($urandom_range(49990, 50010));
         2: raw = 16'($urandom_range(0, 255));
         default: raw = 16'($urandom_range(0, 65535));
      endcase
      ctr = ($urandom_range(0, 6) == 0) ? prev_counter : 4'($urandom_range(0, 15));
      t = speed_frame(raw, ctr);
      pick = $urandom_range(0, 99);
      if (pick >= 70 && pick < 78) begin
         t.payload[63:56] = t.payload[63:56] ^ 8'($urandom_range(1, 255));
      end else if (pick >= 78 && pick < 83) begin
         t = random_fields(KIND_RESET);
      end else if (pick >= 83 && pick < 92) begin
         case ($urandom_range(0, 4))
            0: t.bus_index = 2'($urandom_range(1, 3));
            1: t.is_extended = 1'b1;
            2: t.is_remote = 1'b1;
            3: t.frame_id = t.frame_id ^ 11'($urandom_range(1, 2047));
            default: t.data_length = t.data_length ^ 4'($urandom_range(1, 15));
         endcase
      end else if (pick >= 92) begin
         t = random_fields(KIND_FRAME);
      end
      return t;
   endfunction

   // called at a falling edge; leaves valid high for a back-to-back transaction
   task automatic send_item(req_type t);
      req_valid <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      speed_expect_q.push_back(predict_speed(t));
      @(negedge clock);
   endtask

   task automatic req_pause();
      int n;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: n = 0;
         9: n = $urandom_range(5, 30);
         default: n = $urandom_range(1, 3);
      endcase
      if (gaps_on && n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (speed_expect_q.size() != 0)
         @(negedge clock);
      repeat (RESULT_LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_enables(logic profile, logic ext_speed, logic wired);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_PROFILE_ENABLE;
      csr_data <= profile;
      @(negedge clock);
      csr_index <= CSR_EXT_SPEED_EN;
      csr_data <= ext_speed;
      @(negedge clock);
      csr_index <= CSR_WIRED_SPEED_IN;
      csr_data <= wired;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cfg_profile = profile;
      cfg_ext_speed = ext_speed;
      cfg_wired = wired;
      @(negedge clock);
   endtask

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (speed_expect_q.size() == 0) begin
            $display("%0t: unexpected transaction, expected none actual status %0d",
                     $time, rsp_data.status);
            fail_count++;
         end else begin
            want = speed_expect_q.pop_front();
            check_field("status", 16'(want.status), 16'(rsp_data.status));
            check_field("speed_valid", 16'(want.speed_valid), 16'(rsp_data.speed_valid));
            check_field("speed_value", want.speed_value, rsp_data.speed_value);
         end
      end
   end

   always @(negedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left = RSP_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!rsp_stall_on) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_run == 0) begin
            stall_level = ($urandom_range(0, 2) == 0);
            stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(1, 4);
         end
         rsp_stall <= stall_level;
         stall_run--;
      end
   end

   task automatic test_disabled_at_reset();
      req_type t;
      send_item(speed_frame(16'd1000, 4'd1));
      req_pause();
      t = '1;
      t.kind = KIND_RESET;
      send_item(t);
      wait_drained();
   endtask

   task automatic test_frame_filters();
      req_type t;
      write_enables(1'b1, 1'b0, 1'b0);
      t = speed_frame(16'd100, 4'd1);
      t.bus_index = 2'd1;
      send_item(t);
      t.bus_index = 2'd3;
      send_item(t);
      req_pause();
      t = speed_frame(16'd100, 4'd1);
      t.is_extended = 1'b1;
      send_item(t);
      t = speed_frame(16'd100, 4'd1);
      t.is_remote = 1'b1;
      send_item(t);
      t = speed_frame(16'd100, 4'd1);
      t.frame_id = FRAME_ID + 11'd1;
      send_item(t);
      req_pause();
      t = speed_frame(16'd100, 4'd1);
      t.data_length = 4'd7;
      send_item(t);
      t.data_length = 4'd15;
      send_item(t);
      wait_drained();
   endtask

   task automatic test_speed_decode();
      req_type t;
      send_item(speed_frame(16'd0, 4'd1));
      send_item(speed_frame(SPEED_LIMIT, 4'd2));
      send_item(speed_frame(SPEED_LIMIT + 16'd1, 4'd3));
      req_pause();
      send_item(speed_frame(16'hFFFE, 4'd4));
      send_item(speed_frame(SPEED_INVALID, 4'd5));
      send_item(speed_frame(16'd1234, 4'd5));
      t = speed_frame(16'd777, 4'd6);
      t.payload[63:56] = t.payload[63:56] ^ 8'h01;
      send_item(t);
      req_pause();
      send_item(speed_frame(16'd777, 4'd6));
      send_item(speed_frame(16'd9, 4'd15));
      send_item(speed_frame(16'd10, 4'd0));
      send_item(speed_frame(16'd11, 4'd3));
      t = '1;
      t.kind = KIND_RESET;
      send_item(t);
      send_item(speed_frame(16'd12, 4'd0));
      wait_drained();
   endtask

   task automatic test_source_selection();
      write_enables(1'b1, 1'b1, 1'b0);
      send_item(speed_frame(16'd200, 4'd7));
      wait_drained();
      write_enables(1'b1, 1'b0, 1'b1);
      send_item(speed_frame(16'd201, 4'd8));
      wait_drained();
      write_enables(1'b1, 1'b1, 1'b1);
      send_item(speed_frame(16'd202, 4'd9));
      wait_drained();
      write_enables(1'b0, 1'b1, 1'b1);
      send_item(speed_frame(16'd203, 4'd10));
      wait_drained();
      write_enables(1'b1, 1'b0, 1'b0);
   endtask

   task automatic test_backpressure();
      int i;
      hold_requests++;
      for (i = 0; i < 20; i++)
         send_item(random_item());
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int c;
      int i;
      for (c = 0; c < RANDOM_CHUNKS; c++) begin
         gaps_on = (c % 3 != 0);
         rsp_stall_on = (c % 4 != 1);
         for (i = 0; i < CHUNK_ITEMS; i++) begin
            send_item(random_item());
            req_pause();
         end
         if (c == 5) begin
            wait_drained();
            write_enables(1'b0, 1'b0, 1'b0);
            for (i = 0; i < 20; i++)
               send_item(random_item());
            wait_drained();
            write_enables(1'b1, 1'b0, 1'b0);
         end
      end
      gaps_on = 1'b1;
      rsp_stall_on = 1'b1;
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_disabled_at_reset();
      test_frame_filters();
      test_speed_decode();
      test_source_selection();
      test_backpressure();
      test_random_traffic();
      wait_drained();
      if (fail_count == 0 && speed_expect_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
